// ----- hdl/rcpc_pkg.sv -----
// Shared types and constants for the RC pulse capture block.
package rcpc_pkg;

	localparam int WIDTH_W = 15;
	localparam int LIMIT_W = 16;
	localparam int STAMP_W = 32;
	localparam int REQ_W   = 16;
	localparam int CMP_W   = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int OUT_CH  = 4;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST     = 15'd800;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST     = 15'd2200;
	localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH_RST = 15'd1500;
	localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 16'd100;

	// Item kinds; code 3 is unused and changes nothing
	typedef enum logic [1:0] {
		KIND_EDGE    = 2'd0,
		KIND_TIMEOUT = 2'd1,
		KIND_SET_OUT = 2'd2
	} kind_t;

	// Register indexes (byte address is 4 times the index)
	typedef enum logic [1:0] {
		REG_MIN_WIDTH     = 2'd0,
		REG_MAX_WIDTH     = 2'd1,
		REG_DEFAULT_WIDTH = 2'd2,
		REG_TIMEOUT_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] max_width;
		logic [WIDTH_W-1:0] default_width;
		logic [LIMIT_W-1:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         channel;
		logic               level;
		logic [STAMP_W-1:0] time_us;
		logic [STAMP_W-1:0] time_ms;
		logic [REQ_W-1:0]   request_width;
	} item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic               valid;
	} chan_state_t;

endpackage

// ----- hdl/rcpc_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface rcpc_item_if import rcpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [1:0]         channel;
	logic               level;
	logic [STAMP_W-1:0] time_us;
	logic [STAMP_W-1:0] time_ms;
	logic [REQ_W-1:0]   request_width;

	modport source (output valid, kind, channel, level, time_us, time_ms, request_width,
		input ready);
	modport sink (input valid, kind, channel, level, time_us, time_ms, request_width,
		output ready);
endinterface

interface rcpc_result_if import rcpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] width_ch0;
	logic [WIDTH_W-1:0] width_ch1;
	logic [WIDTH_W-1:0] width_ch2;
	logic [WIDTH_W-1:0] width_ch3;
	logic [OUT_CH-1:0]  valid_mask;
	logic [CMP_W-1:0]   compare_value;
	logic [1:0]         compare_channel;

	modport source (output valid, width_ch0, width_ch1, width_ch2, width_ch3, valid_mask,
		compare_value, compare_channel, input ready);
	modport sink (input valid, width_ch0, width_ch1, width_ch2, width_ch3, valid_mask,
		compare_value, compare_channel, output ready);
endinterface

// ----- hdl/rc_pulse_capture_with_failsafe.sv -----
// Top level of the RC servo pulse capture block with loss-of-signal failsafe.
//
//   channel  dir  handshake      transaction
//   item     in   valid/ready    edge, timeout check or set-output request
//   result   out  valid/ready    channel widths, valid mask, compare value
//   APB      in   psel/penable   configuration register write or read
//
// One item per cycle unless the result stalls: an item is registered on input,
// then committed to channel state and written to the result register together.
// Reset sets widths to 1500 us, clears valid bits and time stamps.
// A stalled result holds in its register; one more item waits in the input stage.
module rc_pulse_capture_with_failsafe import rcpc_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	rcpc_item_if.sink         item,
	rcpc_result_if.source     result
);

	cfg_t               cfg;
	item_t              item_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv;
	chan_state_t        chan_nxt [CHANNELS];
	logic [WIDTH_W-1:0] rep_width [OUT_CH];
	logic [OUT_CH-1:0]  rep_mask;
	logic [WIDTH_W-1:0] clamp_w;
	logic [CMP_W-1:0]   cmp_val;
	logic [1:0]         cmp_ch;

	logic [WIDTH_W-1:0] width_s2 [OUT_CH];
	logic [OUT_CH-1:0]  mask_s2;
	logic [CMP_W-1:0]   cmp_s2;
	logic [1:0]         cmp_ch_s2;

	assign pready = 1'b1;

	rcpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Move the input stage forward whenever the result register frees up
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind          <= item.kind;
			item_s1.channel       <= item.channel;
			item_s1.level         <= item.level;
			item_s1.time_us       <= item.time_us;
			item_s1.time_ms       <= item.time_ms;
			item_s1.request_width <= item.request_width;
		end
	end

	// One state cell per channel
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		rcpc_chan #(.IDX(g)) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.commit (adv),
			.item   (item_s1),
			.cfg    (cfg),
			.nxt    (chan_nxt[g])
		);
	end

	// Report only channels that exist
	for (genvar g = 0; g < OUT_CH; g++) begin : g_rep
		if (g < CHANNELS) begin : g_used
			assign rep_width[g] = chan_nxt[g].width;
			assign rep_mask[g]  = chan_nxt[g].valid;
		end else begin : g_unused
			assign rep_width[g] = '0;
			assign rep_mask[g]  = 1'b0;
		end
	end

	// Clamp the requested output width; an inverted range favors the floor
	always_comb begin
		if (item_s1.request_width < {1'b0, cfg.min_width}) begin
			clamp_w = cfg.min_width;
		end else if (item_s1.request_width > {1'b0, cfg.max_width}) begin
			clamp_w = cfg.max_width;
		end else begin
			clamp_w = item_s1.request_width[WIDTH_W-1:0];
		end
		if (item_s1.kind == KIND_SET_OUT) begin
			cmp_val = {clamp_w, 1'b0};
			cmp_ch  = item_s1.channel;
		end else begin
			cmp_val = '0;
			cmp_ch  = '0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv) begin
			width_s2  <= rep_width;
			mask_s2   <= rep_mask;
			cmp_s2    <= cmp_val;
			cmp_ch_s2 <= cmp_ch;
		end
	end

	assign result.valid           = valid_s2;
	assign result.width_ch0       = width_s2[0];
	assign result.width_ch1       = width_s2[1];
	assign result.width_ch2       = width_s2[2];
	assign result.width_ch3       = width_s2[3];
	assign result.valid_mask      = mask_s2;
	assign result.compare_value   = cmp_s2;
	assign result.compare_channel = cmp_ch_s2;

endmodule

// ----- hdl/rcpc_regs.sv -----
// APB configuration registers for the RC pulse capture block.
module rcpc_regs import rcpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Write the addressed register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width     <= MIN_WIDTH_RST;
			cfg_q.max_width     <= MAX_WIDTH_RST;
			cfg_q.default_width <= DEFAULT_WIDTH_RST;
			cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_WIDTH:     cfg_q.min_width     <= pwdata[WIDTH_W-1:0];
				REG_MAX_WIDTH:     cfg_q.max_width     <= pwdata[WIDTH_W-1:0];
				REG_DEFAULT_WIDTH: cfg_q.default_width <= pwdata[WIDTH_W-1:0];
				REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_MIN_WIDTH:     prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_q.min_width};
			REG_MAX_WIDTH:     prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_q.max_width};
			REG_DEFAULT_WIDTH: prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_q.default_width};
			REG_TIMEOUT_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_q.timeout_limit};
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- hdl/rcpc_chan.sv -----
// Per-channel capture state: rise stamp, measured width, valid flag, update stamp.
module rcpc_chan import rcpc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  item_t       item,
	input  cfg_t        cfg,
	output chan_state_t nxt
);

	logic [STAMP_W-1:0] rise_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [WIDTH_W-1:0] width_q;
	logic               valid_q;

	logic               hit;
	logic               rise_hit;
	logic               fall_ok;
	logic               stale;
	logic [STAMP_W-1:0] pulse_w;
	logic [STAMP_W-1:0] age;

	// Decode what the current item does to this channel
	always_comb begin
		hit      = (item.kind == KIND_EDGE) && (32'(item.channel) == IDX);
		rise_hit = hit && item.level;
		pulse_w  = item.time_us - rise_q;
		fall_ok  = hit && !item.level
			&& (pulse_w >= {{(STAMP_W-WIDTH_W){1'b0}}, cfg.min_width})
			&& (pulse_w <= {{(STAMP_W-WIDTH_W){1'b0}}, cfg.max_width});
		age      = item.time_ms - stamp_q;
		stale    = (item.kind == KIND_TIMEOUT)
			&& (age > {{(STAMP_W-LIMIT_W){1'b0}}, cfg.timeout_limit});
	end

	// Form the state after this item
	always_comb begin
		nxt.width = width_q;
		nxt.valid = valid_q;
		if (fall_ok) begin
			nxt.width = pulse_w[WIDTH_W-1:0];
			nxt.valid = 1'b1;
		end else if (stale) begin
			nxt.width = cfg.default_width;
			nxt.valid = 1'b0;
		end
	end

	// Advance the channel state when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= '0;
			stamp_q <= '0;
			width_q <= DEFAULT_WIDTH_RST;
			valid_q <= 1'b0;
		end else if (commit) begin
			width_q <= nxt.width;
			valid_q <= nxt.valid;
			if (rise_hit) begin
				rise_q <= item.time_us;
			end
			if (fall_ok) begin
				stamp_q <= item.time_ms;
			end
		end
	end

endmodule

// ----- hdl/rcpc_checker.sv -----
// Port-level checks for the RC pulse capture block, bound to the top level.
module rcpc_checker import rcpc_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [WIDTH_W-1:0] width_ch0,
	input logic [WIDTH_W-1:0] width_ch1,
	input logic [WIDTH_W-1:0] width_ch2,
	input logic [WIDTH_W-1:0] width_ch3,
	input logic [OUT_CH-1:0]  valid_mask,
	input logic [CMP_W-1:0]   compare_value,
	input logic [1:0]         compare_channel
);

	// Hold a stalled result's compare fields, valid mask and channel 0 width unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(compare_value)
			&& $stable(compare_channel) && $stable(valid_mask) && $stable(width_ch0))
		else $error("stalled result changed");

	// Compare value in a valid result is even, as a doubled width
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> compare_value[0] == 1'b0)
		else $error("odd compare value");

	// Channels that do not exist report nothing
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((CHANNELS > 3) || (width_ch3 == '0 && !valid_mask[3]))
			&& ((CHANNELS > 2) || (width_ch2 == '0 && !valid_mask[2]))
			&& ((CHANNELS > 1) || (width_ch1 == '0 && !valid_mask[1])))
		else $error("unused channel reported");

	// Present only known values in a valid result
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !$isunknown({width_ch0, width_ch1, width_ch2, width_ch3,
			valid_mask, compare_value, compare_channel}))
		else $error("unknown result field");

endmodule

bind rc_pulse_capture_with_failsafe rcpc_checker #(.CHANNELS(CHANNELS)) u_rcpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.width_ch0       (result.width_ch0),
	.width_ch1       (result.width_ch1),
	.width_ch2       (result.width_ch2),
	.width_ch3       (result.width_ch3),
	.valid_mask      (result.valid_mask),
	.compare_value   (result.compare_value),
	.compare_channel (result.compare_channel)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the RC servo pulse capture block with failsafe.
module tb_top;
	import rcpc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int N_DIRECTED = 24;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 72;
	localparam int LONG_HOLD = 60;
	localparam int SETTLE_CYCLES = 4;

	// One result transaction as the block reports it
	typedef struct packed {
		logic [3:0][WIDTH_W-1:0] widths;
		logic [OUT_CH-1:0]       mask;
		logic [CMP_W-1:0]        cmp;
		logic [1:0]              cmp_ch;
	} reading_t;

	typedef struct packed {
		item_t    it;
		logic     pinned;
		reading_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sink_ready = 1'b0;

	rcpc_item_if item_if ();
	rcpc_result_if res_if ();

	assign res_if.ready = sink_ready;

	rc_pulse_capture_with_failsafe #(.CHANNELS(4)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_if),
		.result  (res_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register mirror and channel state of the capture predictor
	logic [WIDTH_W-1:0] cfg_lo, cfg_hi, cfg_dflt;
	logic [LIMIT_W-1:0] cfg_limit;
	logic [STAMP_W-1:0] rise_at [4];
	logic [STAMP_W-1:0] updated_at [4];
	logic [WIDTH_W-1:0] width_now [4];
	logic               live [4];

	reading_t expected_readings [$];
	int errors = 0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;

	// Pulse train generator state
	logic [STAMP_W-1:0] gen_us, gen_ms;
	logic [STAMP_W-1:0] gen_rise [4];
	logic               gen_high [4];

	function automatic reading_t readout(input int w0, input int w1, input int w2, input int w3,
		input logic [3:0] mask, input int cmp, input int cmp_ch);
		reading_t r;
		r.widths[0] = w0[WIDTH_W-1:0];
		r.widths[1] = w1[WIDTH_W-1:0];
		r.widths[2] = w2[WIDTH_W-1:0];
		r.widths[3] = w3[WIDTH_W-1:0];
		r.mask = mask;
		r.cmp = cmp[CMP_W-1:0];
		r.cmp_ch = cmp_ch[1:0];
		return r;
	endfunction

	function automatic plan_row_t stim_row(input int k, input int ch,
		input int lvl, input int us, input int ms, input int req);
		plan_row_t row;
		row.it.kind = k[1:0];
		row.it.channel = ch[1:0];
		row.it.level = lvl[0];
		row.it.time_us = us[STAMP_W-1:0];
		row.it.time_ms = ms[STAMP_W-1:0];
		row.it.request_width = req[REQ_W-1:0];
		row.pinned = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t pinned_row(input plan_row_t row, input reading_t want);
		plan_row_t r;
		r = row;
		r.pinned = 1'b1;
		r.want = want;
		return r;
	endfunction

	// Advance the channel state by one item and return the reading it causes
	function automatic reading_t predict_reading(input item_t it);
		reading_t r;
		logic [STAMP_W-1:0] span, age;
		logic [WIDTH_W-1:0] clamped;
		r = '0;
		case (it.kind)
			KIND_EDGE: begin
				if (it.level) begin
					rise_at[it.channel] = it.time_us;
				end else begin
					span = it.time_us - rise_at[it.channel];
					if (span >= {17'd0, cfg_lo} && span <= {17'd0, cfg_hi}) begin
						width_now[it.channel] = span[WIDTH_W-1:0];
						updated_at[it.channel] = it.time_ms;
						live[it.channel] = 1'b1;
					end
				end
			end
			KIND_TIMEOUT: begin
				for (int c = 0; c < 4; c++) begin
					age = it.time_ms - updated_at[c];
					if (age > {16'd0, cfg_limit}) begin
						live[c] = 1'b0;
						width_now[c] = cfg_dflt;
					end
				end
			end
			KIND_SET_OUT: begin
				// clamp against the floor first so an inverted range favors min_width
				if (it.request_width < {1'b0, cfg_lo})
					clamped = cfg_lo;
				else if (it.request_width > {1'b0, cfg_hi})
					clamped = cfg_hi;
				else
					clamped = it.request_width[WIDTH_W-1:0];
				r.cmp = {clamped, 1'b0};
				r.cmp_ch = it.channel;
			end
			default: ;
		endcase
		for (int c = 0; c < 4; c++) begin
			r.widths[c] = width_now[c];
			r.mask[c] = live[c];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Drive result ready, run the long hold-off and check each result transaction
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= LONG_HOLD;
			sink_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(99) >= sink_stall_pct);
		end

		if (arst_n && res_if.valid && sink_ready) begin
			got.widths[0] = res_if.width_ch0;
			got.widths[1] = res_if.width_ch1;
			got.widths[2] = res_if.width_ch2;
			got.widths[3] = res_if.width_ch3;
			got.mask = res_if.valid_mask;
			got.cmp = res_if.compare_value;
			got.cmp_ch = res_if.compare_channel;
			if (expected_readings.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
			end else begin
				want = expected_readings.pop_front();
				for (int c = 0; c < 4; c++)
					check_field($sformatf("width_ch%0d", c), want.widths[c], got.widths[c]);
				check_field("valid_mask", want.mask, got.mask);
				check_field("compare_value", want.cmp, got.cmp);
				check_field("compare_channel", want.cmp_ch, got.cmp_ch);
			end
		end
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.kind <= it.kind;
		item_if.channel <= it.channel;
		item_if.level <= it.level;
		item_if.time_us <= it.time_us;
		item_if.time_ms <= it.time_ms;
		item_if.request_width <= it.request_width;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
	endtask

	// Drop valid and wait until every expected result has drained
	task automatic settle();
		item_if.valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_WIDTH:     cfg_lo = val[WIDTH_W-1:0];
			REG_MAX_WIDTH:     cfg_hi = val[WIDTH_W-1:0];
			REG_DEFAULT_WIDTH: cfg_dflt = val[WIDTH_W-1:0];
			REG_TIMEOUT_LIMIT: cfg_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int lo, input int hi, input int dflt, input int limit);
		cfg_write(REG_MIN_WIDTH, lo);
		cfg_write(REG_MAX_WIDTH, hi);
		cfg_write(REG_DEFAULT_WIDTH, dflt);
		cfg_write(REG_TIMEOUT_LIMIT, limit);
	endtask

	// Mostly well-formed rise/fall pairs around the accepted range, plus timeout checks, set-output requests and noise
	task automatic make_random_item(output item_t it);
		int unsigned pick;
		int unsigned step;
		logic [1:0] ch;
		int lo, hi;
		pick = $urandom_range(99);
		ch = 2'($urandom_range(3));
		lo = int'(cfg_lo) - 3;
		if (lo < 0)
			lo = 0;
		hi = int'(cfg_hi) + 3;
		it.kind = KIND_EDGE;
		it.channel = ch;
		it.level = 1'($urandom_range(1));
		it.time_us = $urandom;
		it.time_ms = $urandom;
		it.request_width = 16'($urandom);

		gen_us += $urandom_range(3000);
		step = cfg_limit / 8 + 2;
		if ($urandom_range(19) == 0)
			gen_ms += $urandom;
		else
			gen_ms += $urandom_range(step);

		if (pick < 60) begin
			it.time_ms = gen_ms;
			if (pick < 6) begin
				// leave the random edge as noise
			end else if (!gen_high[ch]) begin
				it.level = 1'b1;
				it.time_us = gen_us;
				gen_rise[ch] = gen_us;
				gen_high[ch] = 1'b1;
			end else begin
				it.level = 1'b0;
				if ($urandom_range(7) == 0)
					it.time_us = gen_rise[ch] + $urandom_range(40000);
				else
					it.time_us = gen_rise[ch] + $urandom_range(hi, lo);
				gen_us = it.time_us;
				gen_high[ch] = 1'b0;
			end
		end else if (pick < 78) begin
			it.kind = KIND_TIMEOUT;
			it.time_ms = gen_ms;
		end else if (pick < 96) begin
			it.kind = KIND_SET_OUT;
			if ($urandom_range(1))
				it.request_width = 16'($urandom_range(hi, lo));
		end else begin
			it.kind = KIND_UNUSED;
		end
	endtask

	initial begin
		plan_row_t plan [N_DIRECTED];
		item_t it;
		reading_t r;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_if.valid = 1'b0;
		item_if.kind = '0;
		item_if.channel = '0;
		item_if.level = 1'b0;
		item_if.time_us = '0;
		item_if.time_ms = '0;
		item_if.request_width = '0;

		cfg_lo = MIN_WIDTH_RST;
		cfg_hi = MAX_WIDTH_RST;
		cfg_dflt = DEFAULT_WIDTH_RST;
		cfg_limit = TIMEOUT_LIMIT_RST;
		for (int c = 0; c < 4; c++) begin
			rise_at[c] = '0;
			updated_at[c] = '0;
			width_now[c] = DEFAULT_WIDTH_RST;
			live[c] = 1'b0;
			gen_rise[c] = '0;
			gen_high[c] = 1'b0;
		end
		gen_us = $urandom;
		gen_ms = $urandom;

		// Directed items under reset settings
		plan = '{
			pinned_row(stim_row(KIND_TIMEOUT, 0, 0, 0, 0, 0),
				readout(1500, 1500, 1500, 1500, 4'h0, 0, 0)),
			pinned_row(stim_row(KIND_SET_OUT, 3, 0, 0, 0, 0),
				readout(1500, 1500, 1500, 1500, 4'h0, 1600, 3)),
			pinned_row(stim_row(KIND_SET_OUT, 1, 0, 0, 0, 16'hFFFF),
				readout(1500, 1500, 1500, 1500, 4'h0, 4400, 1)),
			stim_row(KIND_SET_OUT, 2, 1, 0, 0, 1234),
			pinned_row(stim_row(KIND_UNUSED, 3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
				readout(1500, 1500, 1500, 1500, 4'h0, 0, 0)),
			// falling edge with no rise before it measures from zero
			pinned_row(stim_row(KIND_EDGE, 0, 0, 1000, 5, 0),
				readout(1000, 1500, 1500, 1500, 4'h1, 0, 0)),
			stim_row(KIND_EDGE, 1, 1, 32'hFFFF_FF00, 10, 0),
			stim_row(KIND_EDGE, 1, 0, 32'h0000_0700, 12, 0),
			stim_row(KIND_EDGE, 2, 1, 5000, 14, 0),
			stim_row(KIND_EDGE, 2, 0, 5799, 15, 0),
			stim_row(KIND_EDGE, 2, 1, 6000, 18, 0),
			stim_row(KIND_EDGE, 2, 0, 8200, 20, 0),
			stim_row(KIND_EDGE, 3, 1, 9000, 22, 0),
			stim_row(KIND_EDGE, 3, 0, 11201, 24, 0),
			stim_row(KIND_EDGE, 3, 1, 20000, 26, 0),
			stim_row(KIND_EDGE, 3, 0, 20800, 30, 0),
			stim_row(KIND_TIMEOUT, 0, 0, 0, 110, 0),
			stim_row(KIND_TIMEOUT, 0, 0, 0, 130, 0),
			stim_row(KIND_SET_OUT, 0, 0, 0, 0, 800),
			stim_row(KIND_SET_OUT, 0, 0, 0, 0, 2200),
			stim_row(KIND_EDGE, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
			stim_row(KIND_EDGE, 0, 0, 32'h0000_03FF, 32'hFFFF_FFFF, 0),
			// age wraps to exactly the limit and must not expire
			stim_row(KIND_TIMEOUT, 0, 0, 0, 32'h0000_0063, 0),
			pinned_row(stim_row(KIND_TIMEOUT, 0, 0, 0, 32'h8000_0000, 0),
				readout(1500, 1500, 1500, 1500, 4'h0, 0, 0))
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_item(plan[i].it);
			r = predict_reading(plan[i].it);
			expected_readings.push_back(plan[i].pinned ? plan[i].want : r);
		end

		// Random phases, each applying a register setting and an idle and stall pattern
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			case (p % 5)
				0: apply_setting(MIN_WIDTH_RST, MAX_WIDTH_RST, DEFAULT_WIDTH_RST,
					TIMEOUT_LIMIT_RST);
				1: apply_setting(0, 32767, 0, 0);
				2: apply_setting(32767, 32767, 32767, 65535);
				3: apply_setting(2000, 1000, 1234, 50);
				default: apply_setting($urandom_range(400, 1200), 1200 + $urandom_range(2000),
					$urandom_range(32767), $urandom_range(10, 400));
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 67; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 67; end
				default: begin src_idle_pct = 37; sink_stall_pct = 37; end
			endcase
			// hold off the receiver while items keep coming
			if (p == 4)
				holds_asked++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				make_random_item(it);
				send_item(it);
				expected_readings.push_back(predict_reading(it));
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
